[rtl/length_framed_sum_checked_deframer_top_defines.svh]
// Assertion macros for the length-framed deframer checker
`ifndef LENGTH_FRAMED_SUM_CHECKED_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_FRAMED_SUM_CHECKED_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LFSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lfsd_pkg.sv]
// Types, constants and helpers shared by the deframer modules
`default_nettype none

package lfsd_pkg;

	localparam int CHECK_BYTES_DEF = 2;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int BYTE_W = 8;
	localparam int SUM_W  = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;
	localparam int OUT_W  = 40;

	localparam logic [15:0] HEADER_RST  = 16'h5AA5;
	localparam logic [7:0]  TRAILER_RST = 8'h7E;
	localparam logic [7:0]  MIN_PAY_RST = 8'd3;

	localparam int NUM_TYPES = 6;
	localparam logic [7:0] KNOWN_TYPES [NUM_TYPES] = '{
		8'h41, 8'h51, 8'h61, 8'h70, 8'h81, 8'h90
	};

	typedef enum logic [IDX_W-1:0] {
		CFG_HEADER  = 2'd0,
		CFG_TRAILER = 2'd1,
		CFG_MIN_PAY = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT1   = 3'd0,
		PH_HUNT2   = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4,
		PH_TRAILER = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_TRAILER = 2'd1,
		ST_BAD_SUM     = 2'd2,
		ST_SHORT       = 2'd3
	} frm_status_t;

	// one finished frame, front to back
	typedef struct packed {
		logic              bad_trailer;
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] ftype;
		logic [SUM_W-1:0]  sum;
		logic [SUM_W-1:0]  rx_sum;
	} frm_rec_t;

	typedef struct packed {
		logic       known;
		logic [2:0] idx;
	} type_info_t;

	function automatic type_info_t type_lookup(input logic [BYTE_W-1:0] t);
		type_info_t r;
		r = '0;
		for (int i = 0; i < NUM_TYPES; i++) begin
			if (t == KNOWN_TYPES[i]) begin
				r.known = 1'b1;
				r.idx   = 3'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/lfsd_front.sv]
// Front end: byte-level frame parser, pushes one record per trailer
`default_nettype none

module lfsd_front #(
	parameter int CHECK_BYTES = lfsd_pkg::CHECK_BYTES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_acc,
	input  wire logic [7:0]                in_byte,
	input  wire logic [15:0]               header_word,
	input  wire logic [7:0]                trailer_byte,
	output      logic                      push,
	output      lfsd_pkg::frm_rec_t        rec
);

	lfsd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  left_q, left_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] rx_q, rx_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  left_m1;

	assign left_m1 = left_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lfsd_pkg::PH_HUNT1;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			left_q <= '0;
			sum_q  <= '0;
			rx_q   <= '0;
			type_q <= '0;
		end else begin
			len_q  <= len_d;
			left_q <= left_d;
			sum_q  <= sum_d;
			rx_q   <= rx_d;
			type_q <= type_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		left_d  = left_q;
		sum_d   = sum_q;
		rx_d    = rx_q;
		type_d  = type_q;
		push    = 1'b0;
		rec.bad_trailer = (in_byte != trailer_byte);
		rec.len         = len_q;
		rec.ftype       = type_q;
		rec.sum         = sum_q;
		rec.rx_sum      = rx_q;
		if (in_acc) begin
			unique case (phase_q)
				lfsd_pkg::PH_HUNT2: begin
					if (in_byte == header_word[7:0]) begin
						phase_d = lfsd_pkg::PH_LEN;
					end else if (in_byte == header_word[15:8]) begin
						phase_d = lfsd_pkg::PH_HUNT2;
					end else begin
						phase_d = lfsd_pkg::PH_HUNT1;
					end
				end
				lfsd_pkg::PH_LEN: begin
					len_d  = in_byte;
					left_d = in_byte;
					sum_d  = '0;
					type_d = '0;
					if (in_byte == 8'd0) begin
						phase_d = lfsd_pkg::PH_CHECK;
						left_d  = 8'(CHECK_BYTES);
						rx_d    = '0;
					end else begin
						phase_d = lfsd_pkg::PH_PAYLOAD;
					end
				end
				lfsd_pkg::PH_PAYLOAD: begin
					if (left_q == len_q) begin
						type_d = in_byte;
					end
					sum_d  = sum_q + {8'd0, in_byte};
					left_d = left_m1;
					if (left_m1 == 8'd0) begin
						phase_d = lfsd_pkg::PH_CHECK;
						left_d  = 8'(CHECK_BYTES);
						rx_d    = '0;
					end
				end
				lfsd_pkg::PH_CHECK: begin
					rx_d   = {rx_q[7:0], in_byte};
					left_d = left_m1;
					if (left_m1 == 8'd0) begin
						phase_d = lfsd_pkg::PH_TRAILER;
					end
				end
				lfsd_pkg::PH_TRAILER: begin
					push    = 1'b1;
					phase_d = lfsd_pkg::PH_HUNT1;
					left_d  = '0;
				end
				default: begin
					if (in_byte == header_word[15:8]) begin
						phase_d = lfsd_pkg::PH_HUNT2;
					end else begin
						phase_d = lfsd_pkg::PH_HUNT1;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/lfsd_queue.sv]
// Short record queue between parser and result stage
`default_nettype none

module lfsd_queue #(
	parameter int DEPTH = lfsd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire lfsd_pkg::frm_rec_t push_rec,
	input  wire logic               pop,
	output      logic               full,
	output      logic               head_valid,
	output      lfsd_pkg::frm_rec_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lfsd_pkg::frm_rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          push_ok, pop_ok;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign push_ok    = push && !full;
	assign pop_ok     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= push_rec;
		end
	end

endmodule

`default_nettype wire

[rtl/lfsd_back.sv]
// Back end: frame status, type decode and output register
`default_nettype none

module lfsd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire lfsd_pkg::frm_rec_t          q_head,
	input  wire logic [7:0]                  min_payload,
	output      logic                        q_pop,
	output      logic                        m_tvalid,
	input  wire logic                        m_tready,
	output      logic [lfsd_pkg::OUT_W-1:0]  m_tdata
);

	logic                       valid_q;
	logic [lfsd_pkg::OUT_W-1:0] data_q;
	lfsd_pkg::frm_status_t      status;
	lfsd_pkg::type_info_t       tinfo;

	assign q_pop    = q_valid && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign tinfo    = lfsd_pkg::type_lookup(q_head.ftype);

	always_comb begin
		priority if (q_head.bad_trailer) begin
			status = lfsd_pkg::ST_BAD_TRAILER;
		end else if (q_head.len < min_payload) begin
			status = lfsd_pkg::ST_SHORT;
		end else if (q_head.rx_sum != q_head.sum) begin
			status = lfsd_pkg::ST_BAD_SUM;
		end else begin
			status = lfsd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= {2'b00, q_head.sum, q_head.len, tinfo.known, tinfo.idx,
				q_head.ftype, status};
		end
	end

endmodule

`default_nettype wire

[rtl/length_framed_sum_checked_deframer_top.sv]
// A record is queued, then held in the output register, before it is offered.
// Throughput: one input byte per cycle; results drain one per cycle unless stalled.
// s_tready drops only while the record queue (QUEUE_DEPTH entries) is full.
// Reset: asynchronous, active low; parser to header hunt, queue and output emptied,
// registers to 5AA5h / 7Eh / 3. No clearing pass.
`default_nettype none

module length_framed_sum_checked_deframer_top #(
	parameter int CHECK_BYTES = lfsd_pkg::CHECK_BYTES_DEF,
	parameter int QUEUE_DEPTH = lfsd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output      logic                        s_tready,
	input  wire logic [7:0]                  s_tdata,   // [7:0] in_byte
	output      logic                        m_tvalid,
	input  wire logic                        m_tready,
	// [1:0] frame_status, [9:2] frame_type, [12:10] type_index, [13] type_known,
	// [21:14] payload_len, [37:22] sum_computed, [39:38] zero
	output      logic [lfsd_pkg::OUT_W-1:0]  m_tdata,
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [lfsd_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [lfsd_pkg::CFG_W-1:0]  cfg_data
);

	logic [15:0]        header_q;
	logic [7:0]         trailer_q;
	logic [7:0]         min_pay_q;
	logic               in_acc;
	logic               push;
	logic               q_full;
	logic               q_valid;
	logic               q_pop;
	lfsd_pkg::frm_rec_t push_rec;
	lfsd_pkg::frm_rec_t q_head;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign in_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= lfsd_pkg::HEADER_RST;
			trailer_q <= lfsd_pkg::TRAILER_RST;
			min_pay_q <= lfsd_pkg::MIN_PAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lfsd_pkg::CFG_HEADER:  header_q  <= cfg_data;
				lfsd_pkg::CFG_TRAILER: trailer_q <= cfg_data[7:0];
				lfsd_pkg::CFG_MIN_PAY: min_pay_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lfsd_front #(
		.CHECK_BYTES(CHECK_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_acc       (in_acc),
		.in_byte      (s_tdata),
		.header_word  (header_q),
		.trailer_byte (trailer_q),
		.push         (push),
		.rec          (push_rec)
	);

	lfsd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head)
	);

	lfsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.min_payload (min_pay_q),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

`default_nettype wire

[rtl/lfsd_checker.sv]
// Port-level checker for the deframer, bound to the top level
`default_nettype none
`include "length_framed_sum_checked_deframer_top_defines.svh"

module lfsd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tvalid,
	input wire logic                        s_tready,
	input wire logic [7:0]                  s_tdata,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [lfsd_pkg::OUT_W-1:0]  m_tdata,
	input wire logic                        cfg_valid,
	input wire logic                        cfg_ready,
	input wire logic [lfsd_pkg::IDX_W-1:0]  cfg_index,
	input wire logic [lfsd_pkg::CFG_W-1:0]  cfg_data
);

	logic unused_ok;
	assign unused_ok = ^{s_tvalid, s_tready, s_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

	`LFSD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`LFSD_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`LFSD_ASSERT_IMP(a_unknown_idx, m_tvalid && !m_tdata[13], m_tdata[12:10] == 3'd0, "unknown type with nonzero index")
	`LFSD_ASSERT_IMP(a_idx_range, m_tvalid, (m_tdata[12:10] <= 3'd5) && (m_tdata[39:38] == 2'b00), "type index or padding out of range")

endmodule

bind length_framed_sum_checked_deframer_top lfsd_checker u_lfsd_checker (.*);

`default_nettype wire
